// ----- hw/rtl/ghn_pkg.sv -----
// Package for the grayscale histogram normalizer: default sizes, field widths
// and the action codes carried on the input tuser. No dependencies.
`timescale 1ns / 1ps

package ghn_pkg;

    localparam int NUM_BINS_DEF      = 256;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int PIXEL_W  = 8;
    localparam int ACTION_W = 2;

    // Action codes; code 3 is unused and dropped without a result.
    typedef enum logic [ACTION_W-1:0] {
        ACT_COUNT = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

endpackage

// ----- hw/rtl/grayscale_histogram_normalizer_core.sv -----
// Grayscale histogram normalizer top level: bin memory, running total and a
// bit-serial divider for the normalized share. Depends on ghn_pkg.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one item per handshake. tuser carries the action
//   (count pixel, read bin, clear); tdata carries pixel_value and bin_index.
//   Output stream (m_axis_*): one item per read action, with the share,
//   the bin count, the pixel total and two status flags.
// Timing
//   Count: accept, bin fetch from the registered memory read port, then
//     increment and write back, before the next tready.
//   Read: bin fetch, then the restoring divider, which produces one quotient
//     bit per cycle, FRACTION_BITS + 1 bits, then the output register.
//     An empty histogram skips the divider.
//   Clear: one memory row per cycle over all NUM_BINS rows, then tready returns.
//   Unused action code: no result.
// Reset
//   rst_n low clears total, flags and output valid, then the block sweeps the
//   bin memory to zero with tready low.
// Backpressure
//   The output register holds its item until taken; a new item is accepted
//   meanwhile, and a finished read waits in its done state until the output
//   register frees up.
module grayscale_histogram_normalizer_core #(
    parameter int NUM_BINS        = ghn_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS      = ghn_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS   = ghn_pkg::FRACTION_BITS_DEF,
    localparam int OUT_W = ((FRACTION_BITS + 1 + 2 * COUNT_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] pixel_value, [15:8] bin_index
    input  logic [2*ghn_pkg::PIXEL_W-1:0]     s_axis_tdata,
    // [1:0] action
    input  logic [ghn_pkg::ACTION_W-1:0]      s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // share (FRACTION_BITS+1), bin_count (COUNT_BITS), pixel_total
    // (COUNT_BITS), zero padding to whole bytes
    output logic [OUT_W-1:0]                  m_axis_tdata,
    // [0] histogram_empty, [1] count_saturated
    output logic [1:0]                        m_axis_tuser
);
    import ghn_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int ITER_W = $clog2(FRACTION_BITS + 1);
    localparam int SHARE_W = FRACTION_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    state_t                  state_reg;
    action_t                 op_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    in_range_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [COUNT_BITS-1:0]   total_reg;
    logic                    sat_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic [COUNT_BITS:0]     rem_reg;
    logic [SHARE_W-1:0]      q_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic [COUNT_BITS-1:0]   rd_data_reg;
    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_data_reg;
    logic [1:0]              m_user_reg;

    // Bin memory: one write port, one registered read port
    logic [COUNT_BITS-1:0]   bin_mem [NUM_BINS];
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [COUNT_BITS-1:0]   mem_wdata;

    logic [PIXEL_W-1:0]      pix;
    logic [PIXEL_W-1:0]      idx;
    logic [COUNT_BITS-1:0]   bin_sel;
    logic                    div_ge;
    logic [COUNT_BITS:0]     div_diff;
    logic                    out_load;

    assign pix = s_axis_tdata[PIXEL_W-1:0];
    assign idx = s_axis_tdata[2*PIXEL_W-1:PIXEL_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Count of the addressed bin; zero for a read beyond the bins
    assign bin_sel = in_range_reg ? rd_data_reg : '0;

    // One restoring division step per cycle
    assign div_ge   = (rem_reg >= {1'b0, total_reg});
    assign div_diff = div_ge ? (rem_reg - {1'b0, total_reg}) : rem_reg;

    // A finished read moves into the output register once it is free
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end
        else if (state_reg == ST_UPDATE && op_reg == ACT_COUNT)
        begin
            mem_we    = (rd_data_reg != COUNT_MAX);
            mem_wdata = rd_data_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= bin_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            op_reg       <= ACT_COUNT;
            addr_reg     <= '0;
            in_range_reg <= 1'b0;
            clr_addr_reg <= '0;
            total_reg    <= '0;
            sat_reg      <= 1'b0;
            iter_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            // Load a finished read, else drop the output item once taken
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(NUM_BINS - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        unique case (s_axis_tuser)
                            ACT_COUNT:
                            begin
                                op_reg       <= ACT_COUNT;
                                addr_reg     <= ADDR_W'(pix);
                                in_range_reg <= 1'b1;
                                // Pixels beyond the bins are ignored
                                if (32'(pix) < NUM_BINS)
                                begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            ACT_READ:
                            begin
                                op_reg       <= ACT_READ;
                                addr_reg     <= ADDR_W'(idx);
                                in_range_reg <= (32'(idx) < NUM_BINS);
                                state_reg    <= ST_FETCH;
                            end
                            ACT_CLEAR:
                            begin
                                total_reg <= '0;
                                sat_reg   <= 1'b0;
                                state_reg <= ST_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_FETCH:
                begin
                    state_reg <= ST_UPDATE;
                end

                ST_UPDATE:
                begin
                    if (op_reg == ACT_COUNT)
                    begin
                        if (rd_data_reg == COUNT_MAX || total_reg == COUNT_MAX)
                        begin
                            sat_reg <= 1'b1;
                        end
                        if (total_reg != COUNT_MAX)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg  <= bin_sel;
                        rem_reg  <= {1'b0, bin_sel};
                        q_reg    <= '0;
                        iter_reg <= '0;
                        // Empty histogram: share stays zero, skip the divider
                        state_reg <= (total_reg == '0) ? ST_DONE : ST_DIVIDE;
                    end
                end

                ST_DIVIDE:
                begin
                    q_reg    <= {q_reg[SHARE_W-2:0], div_ge};
                    rem_reg  <= {div_diff[COUNT_BITS-1:0], 1'b0};
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(FRACTION_BITS))
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    // Hold until the output register is free
                    if (out_load)
                    begin
                        m_data_reg  <= OUT_W'({total_reg, cnt_reg, q_reg});
                        m_user_reg  <= {sat_reg, (total_reg == '0)};
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/ghn_checker.sv -----
// Port-level checker for the grayscale histogram normalizer, bound to the
// top level. Depends on ghn_pkg for its defaults and on the top level's ports.
`timescale 1ns / 1ps

module ghn_checker #(
    parameter int COUNT_BITS    = ghn_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = ghn_pkg::FRACTION_BITS_DEF,
    localparam int OUT_W = ((FRACTION_BITS + 1 + 2 * COUNT_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);
    localparam int SHARE_W = FRACTION_BITS + 1;

    logic [SHARE_W-1:0]    share;
    logic [COUNT_BITS-1:0] bin_count;
    logic [COUNT_BITS-1:0] pixel_total;

    assign share       = m_axis_tdata[SHARE_W-1:0];
    assign bin_count   = m_axis_tdata[SHARE_W+COUNT_BITS-1:SHARE_W];
    assign pixel_total = m_axis_tdata[SHARE_W+2*COUNT_BITS-1:SHARE_W+COUNT_BITS];

    // Hold a stalled output item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_share_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> share <= (SHARE_W'(1) << FRACTION_BITS))
        else $error("share above one");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (pixel_total == '0))
                          && (!m_axis_tuser[0] || share == '0))
        else $error("empty flag inconsistent with total or share");

    a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> bin_count <= pixel_total)
        else $error("bin count above total");

    a_full_share: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && pixel_total != '0 && bin_count == pixel_total |->
            share == (SHARE_W'(1) << FRACTION_BITS))
        else $error("full bin does not give share of one");

endmodule

bind grayscale_histogram_normalizer_core ghn_checker #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_ghn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb_top.sv -----
// Self-checking bench for grayscale_histogram_normalizer_core: directed and random
// count, read and clear items, each result checked against an in-bench histogram.
// Depends on ghn_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    import ghn_pkg::*;

    // Default sizes, so that the output layout is the core's usual one.
    localparam int NUM_BINS    = NUM_BINS_DEF;
    localparam int CNT_W       = COUNT_BITS_DEF;
    localparam int FRAC_W      = FRACTION_BITS_DEF;
    localparam int SHARE_W     = FRAC_W + 1;
    localparam int OUT_W       = ((FRAC_W + 1 + 2 * CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * NUM_BINS + 64;

    typedef struct packed {
        logic [FRAC_W:0]    share;
        logic [CNT_W-1:0]   bin_count;
        logic [CNT_W-1:0]   pixel_total;
        logic               empty;
        logic               saturated;
    } bin_report_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [2*PIXEL_W-1:0]      s_axis_tdata = '0;
    logic [ACTION_W-1:0]       s_axis_tuser = ACT_COUNT;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_W-1:0]          m_axis_tdata;
    logic [1:0]                m_axis_tuser;

    // Histogram as the bench expects it to be
    logic [CNT_W-1:0] hist_bins [NUM_BINS];
    logic [CNT_W-1:0] hist_total;
    logic             hist_saturated;

    bin_report_t pending_reports[$];
    int unsigned error_count;
    int unsigned quiet_cycles;
    int unsigned stall_left;
    bit          idle_on = 1'b1;

    grayscale_histogram_normalizer_core #(
        .NUM_BINS      (NUM_BINS),
        .COUNT_BITS    (CNT_W),
        .FRACTION_BITS (FRAC_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("MISMATCH %0t ns: %s got %0d expected %0d", $time, field, got, want);
        error_count++;
    endtask

    function automatic void clear_histogram();
        foreach (hist_bins[i])
            hist_bins[i] = '0;
        hist_total     = '0;
        hist_saturated = 1'b0;
    endfunction

    // Mostly the extreme gray levels, so that reads land on busy bins.
    function automatic logic [PIXEL_W-1:0] pick_level();
        case ($urandom_range(0, 3))
            0: return PIXEL_W'($urandom_range(0, 3));
            1: return PIXEL_W'($urandom_range(252, 255));
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    // Offer one item, hold it until taken, then update the expected histogram.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [PIXEL_W-1:0] pix,
                             logic [PIXEL_W-1:0] idx);
        bin_report_t      rep;
        logic [CNT_W-1:0] cnt;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, pix};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));

        case (act)
            ACT_COUNT:
                if (int'(pix) < NUM_BINS)
                begin
                    if (hist_bins[pix] == CNT_MAX)
                        hist_saturated = 1'b1;
                    else
                        hist_bins[pix]++;
                    if (hist_total == CNT_MAX)
                        hist_saturated = 1'b1;
                    else
                        hist_total++;
                end
            ACT_READ:
            begin
                cnt = (int'(idx) < NUM_BINS) ? hist_bins[idx] : '0;
                rep.bin_count   = cnt;
                rep.pixel_total = hist_total;
                rep.empty       = (hist_total == '0);
                rep.saturated   = hist_saturated;
                // floor(count * 2^FRAC_W / total); zero on an empty histogram
                rep.share = rep.empty ? '0
                          : SHARE_W'((64'(cnt) << FRAC_W) / 64'(hist_total));
                pending_reports.push_back(rep);
            end
            ACT_CLEAR:
                clear_histogram();
            default: ;
        endcase
    endtask

    // Hold the input side until every outstanding read has come back.
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // Result side: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left    <= $urandom_range(1, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare every accepted result with the oldest pending read.
    always @(posedge clk)
    begin
        bin_report_t seen;
        bin_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.share       = m_axis_tdata[FRAC_W:0];
            seen.bin_count   = m_axis_tdata[FRAC_W+1 +: CNT_W];
            seen.pixel_total = m_axis_tdata[FRAC_W+1+CNT_W +: CNT_W];
            seen.empty       = m_axis_tuser[0];
            seen.saturated   = m_axis_tuser[1];
            if (pending_reports.size() == 0)
                report_mismatch("unexpected result, pending reads", 64'd1, 64'd0);
            else
            begin
                want = pending_reports.pop_front();
                if (seen.share !== want.share)
                    report_mismatch("share", 64'(seen.share), 64'(want.share));
                if (seen.bin_count !== want.bin_count)
                    report_mismatch("bin_count", 64'(seen.bin_count),
                                    64'(want.bin_count));
                if (seen.pixel_total !== want.pixel_total)
                    report_mismatch("pixel_total", 64'(seen.pixel_total),
                                    64'(want.pixel_total));
                if (seen.empty !== want.empty)
                    report_mismatch("histogram_empty", 64'(seen.empty),
                                    64'(want.empty));
                if (seen.saturated !== want.saturated)
                    report_mismatch("count_saturated", 64'(seen.saturated),
                                    64'(want.saturated));
            end
        end
    end

    // Stop a hung run: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Reads before anything is counted, and a clear of an empty store.
    task automatic test_empty_histogram();
        send_item(ACT_READ, 8'h00, 8'h00);
        send_item(ACT_READ, 8'hFF, 8'hFF);
        send_item(ACT_CLEAR, 8'h5A, 8'hA5);
        send_item(ACT_READ, 8'hA5, 8'h80);
    endtask

    // The unused action code must leave the store alone and return nothing.
    task automatic test_unused_action();
        send_item(ACT_UNUSED, 8'hFF, 8'hFF);
        send_item(ACT_READ, 8'h00, 8'hFF);
    endtask

    // Lowest, highest and alternating gray levels, plus a read of an empty bin.
    task automatic test_bin_extremes();
        send_item(ACT_COUNT, 8'h00, 8'hFF);
        send_item(ACT_COUNT, 8'hFF, 8'h00);
        send_item(ACT_COUNT, 8'hFF, 8'h00);
        send_item(ACT_COUNT, 8'h55, 8'hAA);
        send_item(ACT_COUNT, 8'hAA, 8'h55);
        send_item(ACT_READ, 8'hFF, 8'h00);
        send_item(ACT_READ, 8'h00, 8'hFF);
        send_item(ACT_READ, 8'hAA, 8'h55);
        send_item(ACT_READ, 8'h55, 8'hAA);
        send_item(ACT_READ, 8'hFE, 8'h01);
    endtask

    // One bin holding every pixel gives a share of exactly 1.0.
    task automatic test_full_share();
        send_item(ACT_CLEAR, 8'h00, 8'h00);
        repeat (3)
            send_item(ACT_COUNT, 8'd200, 8'h00);
        send_item(ACT_READ, 8'h00, 8'd200);
    endtask

    // Pile many pixels into one bin with reads along the way, then grow a
    // second bin; clear must bring counts, total and flags back to zero.
    task automatic test_busy_bin();
        send_item(ACT_CLEAR, 8'h00, 8'h00);
        for (int i = 0; i < 24; i++)
        begin
            send_item(ACT_COUNT, 8'd7, PIXEL_W'($urandom));
            if (i % 8 == 0)
                send_item(ACT_READ, PIXEL_W'($urandom), 8'd7);
        end
        send_item(ACT_READ, 8'h00, 8'd7);
        send_item(ACT_COUNT, 8'd7, 8'h00);
        send_item(ACT_READ, 8'h00, 8'd7);
        send_item(ACT_COUNT, 8'd9, 8'h00);
        send_item(ACT_COUNT, 8'd9, 8'h00);
        send_item(ACT_READ, 8'h00, 8'd9);
        send_item(ACT_READ, 8'h00, 8'd8);
        send_item(ACT_CLEAR, 8'h00, 8'h00);
        send_item(ACT_READ, 8'h00, 8'd7);
        send_item(ACT_COUNT, 8'd7, 8'h00);
        send_item(ACT_READ, 8'h00, 8'd7);
    endtask

    // Random mix weighted toward counting, with reads, clears and stray codes.
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned pick;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                send_item(ACT_COUNT, pick_level(), PIXEL_W'($urandom));
            else if (pick < 92)
                send_item(ACT_READ, PIXEL_W'($urandom), pick_level());
            else if (pick < 96)
                send_item(ACT_CLEAR, PIXEL_W'($urandom), PIXEL_W'($urandom));
            else
                send_item(ACT_UNUSED, PIXEL_W'($urandom), PIXEL_W'($urandom));
        end
    endtask

    // Back-to-back items with both sides always ready.
    task automatic test_steady_stream(int unsigned n_items);
        idle_on = 1'b0;
        test_random_traffic(n_items);
    endtask

    initial
    begin
        error_count = 0;
        clear_histogram();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_histogram();
        test_unused_action();
        test_bin_extremes();
        test_full_share();
        test_busy_bin();
        test_random_traffic(500);
        wait_for_reports();
        test_random_traffic(500);
        test_steady_stream(300);

        wait_for_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
